// File: rtl/uhmg_pkg.sv
// Package for the upper hull max-gap block.
// Holds field widths, default parameter values and the slope unit control type.
// No dependencies.
package uhmg_pkg;

  localparam int unsigned HEIGHT_W        = 32;
  localparam int unsigned GAP_W           = 10;
  localparam int unsigned GAP_MAX         = 1023;
  localparam int unsigned OUT_DATA_W      = 16;
  localparam int unsigned MAX_POINTS_DEF  = 1024;
  localparam int unsigned HEIGHT_BITS_DEF = 32;

  typedef struct packed {
    logic load_a;
    logic load_b;
  } slope_ctrl_t;

endpackage

// File: rtl/uhmg_slope_unit.sv
// Shared slope compare unit: one multiplier forms both cross products in turn.
// Each product is stored with its sign, and the compare reads the stored pair.
// Depends on uhmg_pkg.
module uhmg_slope_unit #(
  parameter int unsigned YW = 32,
  parameter int unsigned XW = 11
) (
  input  logic                 clk_i,
  input  uhmg_pkg::slope_ctrl_t ctrl_i,
  input  logic [YW-1:0]        minuend_i,
  input  logic [YW-1:0]        subtrahend_i,
  input  logic [XW-1:0]        factor_i,
  output logic                 le_o
);

  localparam int unsigned PW = YW + XW;

  logic          neg;
  logic [YW-1:0] mag;
  logic [PW-1:0] prod;
  logic          neg_a_q;
  logic          neg_b_q;
  logic [PW-1:0] mag_a_q;
  logic [PW-1:0] mag_b_q;

  assign neg  = minuend_i < subtrahend_i;
  assign mag  = neg ? (subtrahend_i - minuend_i) : (minuend_i - subtrahend_i);
  assign prod = PW'(mag) * PW'(factor_i);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_a) begin
      neg_a_q <= neg;
      mag_a_q <= prod;
    end
    if (ctrl_i.load_b) begin
      neg_b_q <= neg;
      mag_b_q <= prod;
    end
  end

  // A nonzero difference always gives a nonzero product, since x gaps are positive.
  assign le_o = (neg_a_q && !neg_b_q) ||
                (!neg_a_q && !neg_b_q && (mag_a_q <= mag_b_q)) ||
                (neg_a_q && neg_b_q && (mag_b_q <= mag_a_q));

endmodule

// File: rtl/upper_hull_max_gap.sv
// Upper convex hull of a height stream with the largest x gap between hull vertices.
// Below two stacked vertices an item passes check and push; else check, second product and
// decide, plus a stack read and another check per pop that leaves two or more vertices.
// A last item then adds the done state, which waits until the output register is free.
// Reset clears the control state; the vertex stack memory is not cleared.
// Depends on uhmg_pkg and uhmg_slope_unit.
module upper_hull_max_gap #(
  parameter int unsigned MAX_POINTS  = uhmg_pkg::MAX_POINTS_DEF,
  parameter int unsigned HEIGHT_BITS = uhmg_pkg::HEIGHT_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [uhmg_pkg::HEIGHT_W-1:0]   s_axis_tdata_i,   // height
  input  logic                            s_axis_tlast_i,   // last
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic [uhmg_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,   // max_gap, zero fill
  output logic                            m_axis_tuser_o    // overflow
);

  localparam int unsigned YW = (HEIGHT_BITS < uhmg_pkg::HEIGHT_W) ? HEIGHT_BITS
                                                                  : uhmg_pkg::HEIGHT_W;
  localparam int unsigned XW = $clog2(MAX_POINTS + 2);
  localparam int unsigned DW = $clog2(MAX_POINTS + 1);
  localparam int unsigned AW = $clog2(MAX_POINTS);
  localparam int unsigned GW = (XW > uhmg_pkg::GAP_W) ? XW : uhmg_pkg::GAP_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MULB,
    ST_DECIDE,
    ST_FILL,
    ST_PUSH,
    ST_DONE
  } state_e;

  state_e                    state_q;
  logic [DW-1:0]             depth_q;
  logic [XW-1:0]             next_x_q;
  logic [uhmg_pkg::GAP_W-1:0] best_gap_q;
  logic                      ovf_q;
  logic                      last_q;
  logic [YW-1:0]             new_y_q;
  logic [XW-1:0]             top_x_q;
  logic [YW-1:0]             top_y_q;
  logic [XW-1:0]             sec_x_q;
  logic [YW-1:0]             sec_y_q;
  logic                      out_valid_q;
  logic [uhmg_pkg::GAP_W-1:0] out_gap_q;
  logic                      out_ovf_q;

  logic [XW-1:0]             mem_x [MAX_POINTS];
  logic [YW-1:0]             mem_y [MAX_POINTS];
  logic [XW-1:0]             rd_x_q;
  logic [YW-1:0]             rd_y_q;
  logic                      mem_we;
  logic [AW-1:0]             wr_addr;
  logic [AW-1:0]             rd_addr;
  logic [DW-1:0]             depth_m3;

  uhmg_pkg::slope_ctrl_t     slope_ctrl;
  logic [YW-1:0]             op_min;
  logic [YW-1:0]             op_sub;
  logic [XW-1:0]             op_fac;
  logic                      slope_le;

  logic [XW-1:0]             gap;
  logic [GW-1:0]             gap_ext;
  logic [uhmg_pkg::GAP_W-1:0] gap_sat;
  logic                      accept;
  logic                      out_free;

  assign accept   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_valid_q || m_axis_tready_i;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(uhmg_pkg::OUT_DATA_W - uhmg_pkg::GAP_W){1'b0}}, out_gap_q};
  assign m_axis_tuser_o  = out_ovf_q;

  // The first product is the left slope term, the second the right one.
  always_comb begin
    slope_ctrl.load_a = (state_q == ST_CHECK) && (depth_q >= DW'(2));
    slope_ctrl.load_b = (state_q == ST_MULB);
    if (state_q == ST_CHECK) begin
      op_min = top_y_q;
      op_sub = sec_y_q;
      op_fac = next_x_q - top_x_q;
    end else begin
      op_min = new_y_q;
      op_sub = top_y_q;
      op_fac = top_x_q - sec_x_q;
    end
  end

  uhmg_slope_unit #(
    .YW(YW),
    .XW(XW)
  ) u_slope (
    .clk_i       (clk_i),
    .ctrl_i      (slope_ctrl),
    .minuend_i   (op_min),
    .subtrahend_i(op_sub),
    .factor_i    (op_fac),
    .le_o        (slope_le)
  );

  assign gap     = next_x_q - top_x_q;
  assign gap_ext = GW'(gap);
  assign gap_sat = (gap_ext > GW'(uhmg_pkg::GAP_MAX)) ? uhmg_pkg::GAP_W'(uhmg_pkg::GAP_MAX)
                                                      : gap_ext[uhmg_pkg::GAP_W-1:0];

  assign mem_we   = (state_q == ST_PUSH);
  assign wr_addr  = depth_q[AW-1:0];
  assign depth_m3 = depth_q - DW'(3);
  assign rd_addr  = depth_m3[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_x[wr_addr] <= next_x_q;
      mem_y[wr_addr] <= new_y_q;
    end
    rd_x_q <= mem_x[rd_addr];
    rd_y_q <= mem_y[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      depth_q     <= '0;
      next_x_q    <= XW'(1);
      best_gap_q  <= uhmg_pkg::GAP_W'(1);
      ovf_q       <= 1'b0;
      last_q      <= 1'b0;
      new_y_q     <= '0;
      top_x_q     <= '0;
      top_y_q     <= '0;
      sec_x_q     <= '0;
      sec_y_q     <= '0;
      out_valid_q <= 1'b0;
      out_gap_q   <= '0;
      out_ovf_q   <= 1'b0;
    end else begin
      if (out_valid_q && m_axis_tready_i && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            new_y_q <= s_axis_tdata_i[YW-1:0];
            last_q  <= s_axis_tlast_i;
            if (next_x_q > XW'(MAX_POINTS)) begin
              ovf_q   <= 1'b1;
              state_q <= s_axis_tlast_i ? ST_DONE : ST_IDLE;
            end else begin
              state_q <= ST_CHECK;
            end
          end
        end
        ST_CHECK: begin
          state_q <= (depth_q >= DW'(2)) ? ST_MULB : ST_PUSH;
        end
        ST_MULB: begin
          state_q <= ST_DECIDE;
        end
        ST_DECIDE: begin
          if (slope_le) begin
            top_x_q <= sec_x_q;
            top_y_q <= sec_y_q;
            depth_q <= depth_q - DW'(1);
            state_q <= (depth_q >= DW'(3)) ? ST_FILL : ST_PUSH;
          end else begin
            state_q <= ST_PUSH;
          end
        end
        ST_FILL: begin
          sec_x_q <= rd_x_q;
          sec_y_q <= rd_y_q;
          state_q <= ST_CHECK;
        end
        ST_PUSH: begin
          if ((depth_q != '0) && (gap_sat > best_gap_q)) begin
            best_gap_q <= gap_sat;
          end
          sec_x_q  <= top_x_q;
          sec_y_q  <= top_y_q;
          top_x_q  <= next_x_q;
          top_y_q  <= new_y_q;
          depth_q  <= depth_q + DW'(1);
          next_x_q <= next_x_q + XW'(1);
          state_q  <= last_q ? ST_DONE : ST_IDLE;
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_gap_q   <= best_gap_q;
            out_ovf_q   <= ovf_q;
            depth_q     <= '0;
            next_x_q    <= XW'(1);
            best_gap_q  <= uhmg_pkg::GAP_W'(1);
            ovf_q       <= 1'b0;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
